/* rtl/core/bcra_pkg.sv */
// Shared types and constants of the bitmap contiguous run allocator.
// No dependencies; every other file of the block but bcra_ram takes names from here.
package bcra_pkg;

  // Bitmap geometry
  localparam int unsigned MapBits  = 4096;
  localparam int unsigned WordBits = 16;
  localparam int unsigned NumWords = MapBits / WordBits;
  localparam int unsigned WordIdxW = $clog2(NumWords);
  localparam int unsigned BitOffW  = $clog2(WordBits);
  localparam int unsigned PosW     = WordIdxW + BitOffW;
  localparam int unsigned LenW     = PosW + 1;

  // Beat and configuration field widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_RESERVE = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BUSY    = 2'd2,
    ST_RDONLY  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEARCH_START = 2'd0,
    CFG_MAP_BITS     = 2'd1,
    CFG_READ_ONLY    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_RSV
  } state_e;

  // Result of evaluating one bitmap word during a search
  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] found_start;
    logic [LenW-1:0] next_count;
  } scan_res_t;

endpackage

/* rtl/core/bcra_in_if.sv */
// Command channel of the run allocator: valid/ready plus the command payload.
// Depends on bcra_pkg for field widths.
interface bcra_in_if;
  logic                          valid;
  logic                          ready;
  logic [bcra_pkg::CmdW-1:0]     command;
  logic [bcra_pkg::WordIdxW-1:0] word_index;
  logic [bcra_pkg::WordBits-1:0] word_data;
  logic [bcra_pkg::LenW-1:0]     run_length;
  logic [bcra_pkg::PosW-1:0]     run_start;

  modport source (
    output valid, command, word_index, word_data, run_length, run_start,
    input  ready
  );
  modport sink (
    input  valid, command, word_index, word_data, run_length, run_start,
    output ready
  );
endinterface

/* rtl/core/bcra_out_if.sv */
// Result channel of the run allocator: valid/ready plus status and run start.
// Depends on bcra_pkg for field widths.
interface bcra_out_if;
  logic                         valid;
  logic                         ready;
  logic [bcra_pkg::StatusW-1:0] status;
  logic [bcra_pkg::PosW-1:0]    found_start;

  modport source (
    output valid, status, found_start,
    input  ready
  );
  modport sink (
    input  valid, status, found_start,
    output ready
  );
endinterface

/* rtl/core/bitmap_contiguous_run_allocator.sv */
// Top level of the bitmap contiguous run allocator; uses bcra_pkg, bcra_in_if,
// bcra_out_if, bcra_ram and bcra_word_scan.
//
// Contiguous first-fit run allocator over a 4096-bit allocation bitmap held as
// 256 words of 16 bits in a single RAM (set bit = used). Each command beat
// yields exactly one result beat. Load word writes one bitmap word and its result
// is registered in the cycle the beat is taken, as is the result of a rejected
// command (read-only, hint or start past the usable limit, zero-length search).
// Find run starts at bit 0 of the word holding the search hint and walks one word
// per cycle through the word evaluator. Reserve run does a read-modify-write of
// one word per cycle, stopping at the first used bit (busy), when the length is
// used up, or at the physical end of the map. The block holds ready low while a
// search or reserve is in progress. The result sits in an output register, so a
// new command is taken in the same cycle that the previous result beat is taken.
// Bitmap words that were never loaded read as unknown; there is no clearing
// pass after reset. Configuration (search hint, usable bit count, read-only
// flag) must only be written while the block is idle.
module bitmap_contiguous_run_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bcra_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bcra_pkg::CfgDataW-1:0]   cfg_data_i,
  bcra_in_if.sink                         in_i,
  bcra_out_if.source                      out_o
);

  localparam int unsigned WB   = bcra_pkg::WordBits;
  localparam int unsigned OffW = bcra_pkg::BitOffW;
  localparam int unsigned IdxW = bcra_pkg::WordIdxW;
  localparam int unsigned PW   = bcra_pkg::PosW;
  localparam int unsigned LW   = bcra_pkg::LenW;

  // Configuration registers
  logic [PW-1:0] search_start_q;
  logic [LW-1:0] map_bits_q;
  logic          read_only_q;

  // Sequencer state
  bcra_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  scan_w_q, scan_w_d;
  logic [IdxW-1:0]  last_w_q, last_w_d;
  logic [LW-1:0]    count_q, count_d;
  logic [LW-1:0]    len_q, len_d;
  logic [LW-1:0]    rem_q, rem_d;
  logic [OffW-1:0]  off_q, off_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  bcra_pkg::status_e status_q;
  logic [PW-1:0]     found_q;

  // Result produced this cycle
  logic              produce;
  bcra_pkg::status_e res_status;
  logic [PW-1:0]     res_found;

  // RAM port
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [WB-1:0]   ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [WB-1:0]   ram_rdata;

  logic               in_acc;
  bcra_pkg::cmd_e     cmd;
  logic [LW-1:0]      lim;
  logic [LW-1:0]      lim_m1;
  logic               find_ok;
  logic               rsv_ok;
  bcra_pkg::scan_res_t scan;

  // Reserve word datapath
  logic [LW:0]   rsv_hi;
  logic [OffW:0] rsv_n;
  logic [WB-1:0] rsv_mask;
  logic [WB-1:0] rsv_used;
  logic [WB-1:0] rsv_low;
  logic [WB-1:0] rsv_wdata;
  logic          rsv_busy;
  logic [LW-1:0] rsv_rem_next;
  logic          rsv_done;

  //--------------------------------------------------------------------------
  // Handshake and command decode
  //--------------------------------------------------------------------------
  assign in_i.ready = (state_q == bcra_pkg::S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cmd        = bcra_pkg::cmd_e'(in_i.command);

  // Usable limit: configured bit count capped at the physical size
  assign lim = (map_bits_q > LW'(bcra_pkg::MapBits)) ? LW'(bcra_pkg::MapBits) : map_bits_q;
  // Last usable bit; its word index bounds a search
  assign lim_m1 = lim - LW'(1);

  assign find_ok = !read_only_q && (LW'(search_start_q) < lim) && (in_i.run_length != '0);
  assign rsv_ok  = !read_only_q && (LW'(in_i.run_start) < lim) && (in_i.run_length != '0);

  //--------------------------------------------------------------------------
  // Shared units
  //--------------------------------------------------------------------------
  bcra_ram #(
    .Width (WB),
    .Depth (bcra_pkg::NumWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bcra_word_scan u_scan (
    .word_i     (ram_rdata),
    .word_idx_i (scan_w_q),
    .count_i    (count_q),
    .len_i      (len_q),
    .lim_i      (lim),
    .res_o      (scan)
  );

  // Reserve: bits [off, off + rem) of the current word, capped at the word end
  assign rsv_hi = (LW+1)'(off_q) + (LW+1)'(rem_q);

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      rsv_mask[j] = (OffW'(j) >= off_q) && ((LW+1)'(j) < rsv_hi);
    end
  end

  assign rsv_n        = (rsv_hi > (LW+1)'(WB)) ? ((OffW+1)'(WB) - (OffW+1)'(off_q))
                                               : (OffW+1)'(rem_q);
  assign rsv_used     = ram_rdata & rsv_mask;
  assign rsv_busy     = |rsv_used;
  // Lowest used bit isolated; set only the masked bits below it
  assign rsv_low      = rsv_used & (~rsv_used + WB'(1));
  assign rsv_wdata    = ram_rdata | (rsv_busy ? (rsv_mask & (rsv_low - WB'(1))) : rsv_mask);
  assign rsv_rem_next = rem_q - LW'(rsv_n);
  assign rsv_done     = rsv_busy || (rsv_rem_next == '0) ||
                        (scan_w_q == IdxW'(bcra_pkg::NumWords - 1));

  //--------------------------------------------------------------------------
  // Next state
  //--------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcra_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            bcra_pkg::CMD_FIND:    if (find_ok) state_d = bcra_pkg::S_FIND;
            bcra_pkg::CMD_RESERVE: if (rsv_ok) state_d = bcra_pkg::S_RSV;
            default:               state_d = bcra_pkg::S_IDLE;
          endcase
        end
      end
      bcra_pkg::S_FIND: begin
        if (scan.hit || (scan_w_q == last_w_q)) state_d = bcra_pkg::S_IDLE;
      end
      bcra_pkg::S_RSV: begin
        if (rsv_done) state_d = bcra_pkg::S_IDLE;
      end
      default: state_d = bcra_pkg::S_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Datapath control and results
  //--------------------------------------------------------------------------
  always_comb begin
    produce    = 1'b0;
    res_status = bcra_pkg::ST_OK;
    res_found  = '0;
    ram_we     = 1'b0;
    ram_waddr  = scan_w_q;
    ram_wdata  = rsv_wdata;
    // Prefetch the next word while the current one is evaluated
    ram_raddr  = scan_w_q + IdxW'(1);
    scan_w_d   = scan_w_q;
    last_w_d   = last_w_q;
    count_d    = count_q;
    len_d      = len_q;
    rem_d      = rem_q;
    off_d      = off_q;

    unique case (state_q)
      bcra_pkg::S_IDLE: begin
        ram_raddr = (cmd == bcra_pkg::CMD_RESERVE) ? in_i.run_start[PW-1:OffW]
                                                   : search_start_q[PW-1:OffW];
        if (in_acc) begin
          unique case (cmd)
            bcra_pkg::CMD_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = in_i.word_index;
              ram_wdata = in_i.word_data;
              produce   = 1'b1;
            end
            bcra_pkg::CMD_FIND: begin
              if (read_only_q) begin
                produce    = 1'b1;
                res_status = bcra_pkg::ST_RDONLY;
              end else if (!find_ok) begin
                produce    = 1'b1;
                res_status = bcra_pkg::ST_NOSPACE;
              end else begin
                scan_w_d = search_start_q[PW-1:OffW];
                last_w_d = lim_m1[PW-1:OffW];
                count_d  = '0;
                len_d    = in_i.run_length;
              end
            end
            bcra_pkg::CMD_RESERVE: begin
              if (read_only_q) begin
                produce    = 1'b1;
                res_status = bcra_pkg::ST_RDONLY;
              end else if (LW'(in_i.run_start) >= lim) begin
                produce    = 1'b1;
                res_status = bcra_pkg::ST_NOSPACE;
              end else if (in_i.run_length == '0) begin
                produce    = 1'b1;
              end else begin
                scan_w_d = in_i.run_start[PW-1:OffW];
                off_d    = in_i.run_start[OffW-1:0];
                rem_d    = in_i.run_length;
              end
            end
            default: produce = 1'b1;
          endcase
        end
      end
      bcra_pkg::S_FIND: begin
        if (scan.hit) begin
          produce   = 1'b1;
          res_found = scan.found_start;
        end else if (scan_w_q == last_w_q) begin
          produce    = 1'b1;
          res_status = bcra_pkg::ST_NOSPACE;
        end else begin
          scan_w_d = scan_w_q + IdxW'(1);
          count_d  = scan.next_count;
        end
      end
      bcra_pkg::S_RSV: begin
        ram_we = 1'b1;
        if (rsv_busy) begin
          produce    = 1'b1;
          res_status = bcra_pkg::ST_BUSY;
        end else if (rsv_done) begin
          produce = 1'b1;
        end else begin
          scan_w_d = scan_w_q + IdxW'(1);
          rem_d    = rsv_rem_next;
          off_d    = '0;
        end
      end
      default: produce = 1'b0;
    endcase
  end

  // Hold a result until the sink takes it; a new one only lands in a free slot
  assign out_valid_d = produce || (out_valid_q && !out_o.ready);

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.found_start = found_q;

  //--------------------------------------------------------------------------
  // Registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bcra_pkg::S_IDLE;
      out_valid_q    <= 1'b0;
      search_start_q <= '0;
      map_bits_q     <= LW'(bcra_pkg::MapBits);
      read_only_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (bcra_pkg::cfg_idx_e'(cfg_idx_i))
          bcra_pkg::CFG_SEARCH_START: search_start_q <= cfg_data_i[PW-1:0];
          bcra_pkg::CFG_MAP_BITS:     map_bits_q     <= cfg_data_i[LW-1:0];
          bcra_pkg::CFG_READ_ONLY:    read_only_q    <= cfg_data_i[0];
          default:                    read_only_q    <= read_only_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_w_q <= scan_w_d;
    last_w_q <= last_w_d;
    count_q  <= count_d;
    len_q    <= len_d;
    rem_q    <= rem_d;
    off_q    <= off_d;
    if (produce) begin
      status_q <= res_status;
      found_q  <= res_found;
    end
  end

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |-> (!out_valid_q || out_o.ready))
    else $error("result produced while output slot still full");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcra_pkg::S_FIND) |-> (scan_w_q <= last_w_q))
    else $error("search walked past the last usable word");

  a_rsv_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcra_pkg::S_RSV) |-> (rem_q != '0))
    else $error("reserve in progress with nothing left to set");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != bcra_pkg::ST_OK)) |-> (found_q == '0))
    else $error("non-ok result carries a run start");

endmodule

/* rtl/core/bcra_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bcra_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/bcra_word_scan.sv */
// Evaluates one bitmap word of a first-fit search against the running free count.
// Depends on bcra_pkg for geometry and the scan_res_t result struct.
module bcra_word_scan (
  input  logic [bcra_pkg::WordBits-1:0] word_i,
  input  logic [bcra_pkg::WordIdxW-1:0] word_idx_i,
  input  logic [bcra_pkg::LenW-1:0]     count_i,
  input  logic [bcra_pkg::LenW-1:0]     len_i,
  input  logic [bcra_pkg::LenW-1:0]     lim_i,
  output bcra_pkg::scan_res_t           res_o
);

  localparam int unsigned WB   = bcra_pkg::WordBits;
  localparam int unsigned OffW = bcra_pkg::BitOffW;
  localparam int unsigned LW   = bcra_pkg::LenW;

  logic [WB-1:0]   free;
  logic [WB-1:0]   all_free;
  logic [OffW:0]   run [WB];
  logic [WB-1:0]   hit;
  logic [LW-1:0]   need;
  logic [OffW-1:0] pos;

  // Free and inside the usable limit
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      free[j] = !word_i[j] && (LW'({word_idx_i, OffW'(j)}) < lim_i);
    end
  end

  // Free run ending at each bit, found from the nearest blocking bit below it
  always_comb begin
    logic            blocked;
    logic [OffW-1:0] last;
    for (int j = 0; j < WB; j++) begin
      blocked = 1'b0;
      last    = '0;
      for (int k = 0; k < WB; k++) begin
        if (k <= j && !free[k]) begin
          blocked = 1'b1;
          last    = OffW'(k);
        end
      end
      all_free[j] = !blocked;
      run[j]      = blocked ? ((OffW+1)'(j) - (OffW+1)'(last)) : (OffW+1)'(j + 1);
    end
  end

  // A run touching bit 0 extends the count carried in from earlier words
  assign need = len_i - count_i;

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      hit[j] = free[j] && (all_free[j] ? (LW'(j + 1) >= need) : (LW'(run[j]) >= len_i));
    end
  end

  // Lowest completing bit wins
  always_comb begin
    pos = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (hit[j]) begin
        pos = OffW'(j);
      end
    end
  end

  always_comb begin
    res_o.hit         = |hit;
    res_o.found_start = bcra_pkg::PosW'(LW'({word_idx_i, pos}) + LW'(1) - len_i);
    res_o.next_count  = all_free[WB-1] ? (count_i + LW'(WB)) : LW'(run[WB-1]);
  end

endmodule

/* tb/bitmap_contiguous_run_allocator_test.sv */
// Self-checking bench for the bitmap contiguous run allocator: loads, first-fit
// searches and reserves against an in-bench bitmap predictor, with random gaps.
// Depends on bcra_pkg, bcra_in_if, bcra_out_if and the allocator top level.
module bitmap_contiguous_run_allocator_test;

  localparam int unsigned CmdW     = bcra_pkg::CmdW;
  localparam int unsigned WordIdxW = bcra_pkg::WordIdxW;
  localparam int unsigned WordBits = bcra_pkg::WordBits;
  localparam int unsigned LenW     = bcra_pkg::LenW;
  localparam int unsigned PosW     = bcra_pkg::PosW;
  localparam int unsigned CfgIdxW  = bcra_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = bcra_pkg::CfgDataW;
  localparam int unsigned NumWords = bcra_pkg::NumWords;
  localparam int unsigned MapBits  = bcra_pkg::MapBits;

  // Command code with no operation behind it; the block must answer it with ok
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  // Cycles to idle after the last result: one full-map scan plus margin
  localparam int unsigned TailCycles = 260;
  // Length of the deliberate receiver hold-off that backs the block up
  localparam int unsigned HoldOffCycles = 400;

  typedef struct packed {
    logic [CmdW-1:0]     command;
    logic [WordIdxW-1:0] word_index;
    logic [WordBits-1:0] word_data;
    logic [LenW-1:0]     run_length;
    logic [PosW-1:0]     run_start;
  } alloc_cmd_t;

  typedef struct packed {
    bcra_pkg::status_e status;
    logic [PosW-1:0]   found_start;
  } outcome_t;

  // One row of the directed table: either a register write or a command beat,
  // the latter optionally with its result typed in by hand
  typedef struct {
    bit                  is_cfg;
    bcra_pkg::cfg_idx_e  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    alloc_cmd_t          beat;
    bit                  typed;
    outcome_t            want;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bcra_in_if  cmd_if ();
  bcra_out_if res_if ();

  bitmap_contiguous_run_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block: bitmap plus the three registers
  logic [WordBits-1:0] shadow_map [NumWords];
  logic [PosW-1:0]     shadow_hint;
  logic [CfgDataW-1:0] shadow_bits;
  logic                shadow_ro;

  // Outcomes of accepted command beats, oldest first
  outcome_t pending_outcomes [$];
  step_row_t directed_steps [$];

  int unsigned mismatches;
  int unsigned n_loads, n_finds, n_reserves, n_other, n_reg_writes;
  int unsigned n_found, n_nospace, n_busy, n_rdonly;

  // Last successful search, so a reserve can claim exactly that run
  bit              claim_ready;
  logic [PosW-1:0] claim_start;
  logic [LenW-1:0] claim_len;
  int unsigned     sender_burst;

  // Receiver side
  bit          hold_req, hold_done;
  int unsigned hold_left, stall_left, steady_left, sink_roll;
  outcome_t    want_now;

  function automatic int unsigned usable_bits();
    if (shadow_bits > MapBits) return MapBits;
    return int'(shadow_bits);
  endfunction

  // First fit from bit 0 of the hint's word; a used bit restarts the count
  function automatic outcome_t first_fit_search(int unsigned len);
    outcome_t    o;
    int unsigned lim, cnt, b;
    o.status      = bcra_pkg::ST_NOSPACE;
    o.found_start = '0;
    lim = usable_bits();
    cnt = 0;
    if (shadow_hint >= lim || len == 0) return o;
    for (b = (shadow_hint / WordBits) * WordBits; b < lim; b++) begin
      if (shadow_map[b / WordBits][b % WordBits]) begin
        cnt = 0;
      end else begin
        cnt++;
        if (cnt == len) begin
          o.status      = bcra_pkg::ST_OK;
          o.found_start = PosW'(b - (len - 1));
          return o;
        end
      end
    end
    return o;
  endfunction

  // Set bits one at a time; stop at the first used bit, leaving earlier ones set.
  // The usable limit gates only the start, the physical end gates the walk.
  function automatic bcra_pkg::status_e reserve_bits(int unsigned first, int unsigned len);
    int unsigned b, done;
    done = 0;
    if (first >= usable_bits()) return bcra_pkg::ST_NOSPACE;
    if (len == 0) return bcra_pkg::ST_OK;
    for (b = first; b < MapBits; b++) begin
      if (shadow_map[b / WordBits][b % WordBits]) return bcra_pkg::ST_BUSY;
      shadow_map[b / WordBits][b % WordBits] = 1'b1;
      done++;
      if (done == len) return bcra_pkg::ST_OK;
    end
    return bcra_pkg::ST_OK;
  endfunction

  function automatic outcome_t apply_command(alloc_cmd_t c);
    outcome_t o;
    o.status      = bcra_pkg::ST_OK;
    o.found_start = '0;
    case (c.command)
      bcra_pkg::CMD_LOAD: begin
        shadow_map[c.word_index] = c.word_data;
      end
      bcra_pkg::CMD_FIND: begin
        if (shadow_ro) o.status = bcra_pkg::ST_RDONLY;
        else o = first_fit_search(c.run_length);
      end
      bcra_pkg::CMD_RESERVE: begin
        if (shadow_ro) o.status = bcra_pkg::ST_RDONLY;
        else o.status = reserve_bits(c.run_start, c.run_length);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic alloc_cmd_t random_fields();
    alloc_cmd_t c;
    c.command    = CmdW'($urandom_range(3, 0));
    c.word_index = WordIdxW'($urandom);
    c.word_data  = WordBits'($urandom);
    c.run_length = LenW'($urandom);
    c.run_start  = PosW'($urandom);
    return c;
  endfunction

  // Mostly short runs; now and then long ones, zero, or past the whole map
  function automatic logic [LenW-1:0] pick_run_length();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 70) return LenW'($urandom_range(20, 1));
    if (roll < 88) return LenW'($urandom_range(200, 21));
    if (roll < 94) return LenW'($urandom_range(MapBits, 201));
    if (roll < 97) return '0;
    return LenW'($urandom_range((1 << LenW) - 1, MapBits + 1));
  endfunction

  // Bias towards empty words so that reserves do not choke the map for good
  function automatic logic [WordBits-1:0] pick_word_pattern();
    int unsigned         roll;
    logic [WordBits-1:0] a, b;
    roll = $urandom_range(99, 0);
    a = WordBits'($urandom);
    b = WordBits'($urandom);
    if (roll < 40) return '0;
    if (roll < 50) return '1;
    if (roll < 70) return a & b & WordBits'($urandom);
    if (roll < 85) return a | b;
    return a;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (sender_burst > 0) begin
      sender_burst--;
      return 0;
    end
    if (roll < 3) sender_burst = 40;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  function automatic step_row_t reg_row(bcra_pkg::cfg_idx_e idx,
                                        logic [CfgDataW-1:0] value);
    step_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = value;
    r.beat    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic step_row_t beat_row(logic [CmdW-1:0] cmd, logic [WordIdxW-1:0] widx,
                                         logic [WordBits-1:0] wdata, logic [LenW-1:0] len,
                                         logic [PosW-1:0] start);
    step_row_t r;
    r.is_cfg          = 1'b0;
    r.reg_idx         = bcra_pkg::CFG_SEARCH_START;
    r.reg_val         = '0;
    r.beat.command    = cmd;
    r.beat.word_index = widx;
    r.beat.word_data  = wdata;
    r.beat.run_length = len;
    r.beat.run_start  = start;
    r.typed           = 1'b0;
    r.want            = '0;
    return r;
  endfunction

  function automatic step_row_t fixed_row(logic [CmdW-1:0] cmd, logic [WordIdxW-1:0] widx,
                                          logic [WordBits-1:0] wdata, logic [LenW-1:0] len,
                                          logic [PosW-1:0] start, bcra_pkg::status_e st,
                                          logic [PosW-1:0] found);
    step_row_t r;
    r = beat_row(cmd, widx, wdata, len, start);
    r.typed            = 1'b1;
    r.want.status      = st;
    r.want.found_start = found;
    return r;
  endfunction

  // Offer one command beat after a random gap, hold it until taken, then
  // predict its outcome. Keep valid high across back-to-back beats.
  task automatic send_beat(input alloc_cmd_t c, input bit typed, input outcome_t typed_want);
    int unsigned gap;
    outcome_t    got;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= c.command;
    cmd_if.word_index <= c.word_index;
    cmd_if.word_data  <= c.word_data;
    cmd_if.run_length <= c.run_length;
    cmd_if.run_start  <= c.run_start;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    got = apply_command(c);
    case (c.command)
      bcra_pkg::CMD_LOAD:    n_loads++;
      bcra_pkg::CMD_FIND:    n_finds++;
      bcra_pkg::CMD_RESERVE: n_reserves++;
      default:               n_other++;
    endcase
    case (got.status)
      bcra_pkg::ST_NOSPACE: n_nospace++;
      bcra_pkg::ST_BUSY:    n_busy++;
      bcra_pkg::ST_RDONLY:  n_rdonly++;
      default:              if (c.command == bcra_pkg::CMD_FIND) n_found++;
    endcase
    if (c.command == bcra_pkg::CMD_FIND && got.status == bcra_pkg::ST_OK) begin
      claim_ready = 1'b1;
      claim_start = got.found_start;
      claim_len   = c.run_length;
    end
    if (typed) pending_outcomes.push_back(typed_want);
    else pending_outcomes.push_back(got);
  endtask

  // Drop valid and wait until every outstanding result beat has come back
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_reg(input bcra_pkg::cfg_idx_e idx,
                             input logic [CfgDataW-1:0] value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bcra_pkg::CFG_SEARCH_START: shadow_hint = value[PosW-1:0];
      bcra_pkg::CFG_MAP_BITS:     shadow_bits = value;
      bcra_pkg::CFG_READ_ONLY:    shadow_ro   = value[0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Result side: check each taken beat against the oldest prediction, then
  // choose next cycle's ready. Short stalls, the odd long one, steady stretches,
  // and one long hold-off on request so the block backs up into its input.
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d found_start %0d",
                   $time, res_if.status, res_if.found_start);
          mismatches++;
        end else begin
          want_now = pending_outcomes.pop_front();
          if (res_if.status !== want_now.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want_now.status,
                     res_if.status);
            mismatches++;
          end
          if (res_if.found_start !== want_now.found_start) begin
            $display("%0t: found_start expected %0d, got %0d", $time,
                     want_now.found_start, res_if.found_start);
            mismatches++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HoldOffCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        res_if.ready <= 1'b1;
      end else begin
        sink_roll = $urandom_range(99, 0);
        if (sink_roll < 5) steady_left = 60;
        else if (sink_roll < 22) stall_left = $urandom_range(3, 1);
        else if (sink_roll < 25) stall_left = $urandom_range(60, 15);
        res_if.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Hang guard: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    alloc_cmd_t  c;
    outcome_t    none;
    int unsigned phase, k, items, roll;
    none = '0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_data_i        <= '0;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= '0;
    cmd_if.word_index <= '0;
    cmd_if.word_data  <= '0;
    cmd_if.run_length <= '0;
    cmd_if.run_start  <= '0;
    shadow_hint = '0;
    shadow_bits = CfgDataW'(MapBits);
    shadow_ro   = 1'b0;
    for (k = 0; k < NumWords; k++) shadow_map[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every word before anything reads the map: unloaded words are unknown
    for (k = 0; k < NumWords; k++) begin
      c            = random_fields();
      c.command    = bcra_pkg::CMD_LOAD;
      c.word_index = WordIdxW'(k);
      c.word_data  = '0;
      send_beat(c, 1'b0, none);
    end

    // Directed table. Map is clear, hint 0, full map usable, writable.
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_LOAD, 8'd0, 16'hFFFF, 13'd0, 12'd0,
                                       bcra_pkg::ST_OK, 12'd0));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_LOAD, 8'd255, 16'h0000, 13'h1FFF,
                                       12'hFFF, bcra_pkg::ST_OK, 12'd0));
    // word 0 full, so the first free bit is the first of word 1
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd1, 12'd0,
                                       bcra_pkg::ST_OK, 12'd16));
    // zero-length search, and a run longer than the whole map
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd0, 12'd0,
                                       bcra_pkg::ST_NOSPACE, 12'd0));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'h1FFF, 12'd0,
                                       bcra_pkg::ST_NOSPACE, 12'd0));
    directed_steps.push_back(beat_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd4080, 12'd0));
    // reserve running off the physical end stops there with ok
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'h1FFF,
                                       12'hFFF, bcra_pkg::ST_OK, 12'd0));
    directed_steps.push_back(beat_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd3, 12'd20));
    // hits the run above partway; the two bits before it stay set
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd4, 12'd18,
                                       bcra_pkg::ST_BUSY, 12'd0));
    directed_steps.push_back(beat_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd2, 12'd0));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd1, 12'd0,
                                       bcra_pkg::ST_BUSY, 12'd0));
    // zero-length reserve sets nothing
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd0, 12'd100,
                                       bcra_pkg::ST_OK, 12'd0));
    directed_steps.push_back(fixed_row(CmdUnused, 8'hA5, 16'h5AA5, 13'h0F0F, 12'h3C3,
                                       bcra_pkg::ST_OK, 12'd0));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_MAP_BITS, 13'd100));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd1, 12'd100,
                                       bcra_pkg::ST_NOSPACE, 12'd0));
    // start inside the usable limit, run carries on past it
    directed_steps.push_back(beat_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd10, 12'd99));
    // run would end past the usable limit
    directed_steps.push_back(beat_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd90, 12'd0));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_SEARCH_START, 13'd4095));
    // hint beyond the usable limit
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd1, 12'd0,
                                       bcra_pkg::ST_NOSPACE, 12'd0));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_MAP_BITS, 13'h1FFF));
    // run found below the unaligned hint; then no wrap back to the map start
    directed_steps.push_back(beat_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd1, 12'd0));
    directed_steps.push_back(beat_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd16, 12'd0));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_SEARCH_START, 13'd37));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_READ_ONLY, 13'd1));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd1, 12'd0,
                                       bcra_pkg::ST_RDONLY, 12'd0));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd1, 12'd0,
                                       bcra_pkg::ST_RDONLY, 12'd0));
    // loads go through even when read-only
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_LOAD, 8'd1, 16'h5555, 13'd0, 12'd0,
                                       bcra_pkg::ST_OK, 12'd0));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_READ_ONLY, 13'd0));
    directed_steps.push_back(beat_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd3, 12'd0));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_MAP_BITS, 13'd0));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd1, 12'd0,
                                       bcra_pkg::ST_NOSPACE, 12'd0));
    directed_steps.push_back(fixed_row(bcra_pkg::CMD_RESERVE, 8'd0, 16'd0, 13'd1, 12'd0,
                                       bcra_pkg::ST_NOSPACE, 12'd0));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_MAP_BITS, 13'd1));
    directed_steps.push_back(reg_row(bcra_pkg::CFG_SEARCH_START, 13'd0));
    directed_steps.push_back(beat_row(bcra_pkg::CMD_FIND, 8'd0, 16'd0, 13'd1, 12'd0));

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg)
        program_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      else
        send_beat(directed_steps[i].beat, directed_steps[i].typed, directed_steps[i].want);
    end

    // Random phases, each under its own register setting. Most traffic is
    // search-then-claim pairs over a churning map; the rest is noise.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          program_reg(bcra_pkg::CFG_SEARCH_START, 13'd0);
          program_reg(bcra_pkg::CFG_MAP_BITS, CfgDataW'(MapBits));
          program_reg(bcra_pkg::CFG_READ_ONLY, 13'd0);
        end
        1: begin
          program_reg(bcra_pkg::CFG_SEARCH_START, CfgDataW'($urandom_range(MapBits - 1, 0)));
          program_reg(bcra_pkg::CFG_MAP_BITS, CfgDataW'($urandom_range(MapBits, 1)));
        end
        2: begin
          program_reg(bcra_pkg::CFG_SEARCH_START,
                      CfgDataW'($urandom_range(MapBits - 1, MapBits - 300)));
          program_reg(bcra_pkg::CFG_MAP_BITS, 13'h1FFF);
        end
        3: begin
          program_reg(bcra_pkg::CFG_READ_ONLY, 13'd1);
          program_reg(bcra_pkg::CFG_MAP_BITS, CfgDataW'($urandom_range(MapBits, 1)));
        end
        4: begin
          program_reg(bcra_pkg::CFG_READ_ONLY, 13'd0);
          program_reg(bcra_pkg::CFG_SEARCH_START, CfgDataW'($urandom_range(MapBits - 1, 0)));
          program_reg(bcra_pkg::CFG_MAP_BITS, CfgDataW'($urandom_range(MapBits, 2000)));
        end
        default: begin
          program_reg(bcra_pkg::CFG_SEARCH_START, CfgDataW'($urandom_range(255, 0)));
          program_reg(bcra_pkg::CFG_MAP_BITS, CfgDataW'(MapBits));
        end
      endcase
      claim_ready = 1'b0;
      items = (phase == 3) ? 28 : 88;
      for (k = 0; k < items; k++) begin
        c    = random_fields();
        roll = $urandom_range(99, 0);
        if (roll < 22) begin
          c.command   = bcra_pkg::CMD_LOAD;
          c.word_data = pick_word_pattern();
        end else if (roll < 55) begin
          c.command    = bcra_pkg::CMD_FIND;
          c.run_length = pick_run_length();
        end else if (roll < 85 && claim_ready) begin
          c.command    = bcra_pkg::CMD_RESERVE;
          c.run_start  = claim_start;
          c.run_length = claim_len;
          claim_ready  = 1'b0;
        end else if (roll < 95) begin
          c.command    = bcra_pkg::CMD_RESERVE;
          c.run_length = pick_run_length();
        end
        // Ask the receiver to sit on its ready while beats keep coming
        if (phase == 2 && k == 40) hold_req = 1'b1;
        send_beat(c, 1'b0, none);
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    $display("Run covered %0d loads, %0d searches, %0d reserves, %0d unused-code beats, %0d %s",
             n_loads, n_finds, n_reserves, n_other, n_reg_writes, "register writes.");
    $display("Outcomes seen: %0d runs found, %0d no space, %0d busy, %0d read-only rejects.",
             n_found, n_nospace, n_busy, n_rdonly);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bcra_pkg.sv
rtl/core/bcra_in_if.sv
rtl/core/bcra_out_if.sv
rtl/core/bcra_ram.sv
rtl/core/bcra_word_scan.sv
rtl/core/bitmap_contiguous_run_allocator.sv
tb/bitmap_contiguous_run_allocator_test.sv
